>>> hw/rtl/set_assoc_cache_fifo_sim_top_macros.svh
// Assertion macros for the set-associative cache tag block.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef SET_ASSOC_CACHE_FIFO_SIM_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_FIFO_SIM_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SACF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SACF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sacf_pkg.sv
// Shared geometry, types and codes for the set-associative cache tag block.
// No dependencies; imported by the top level and by sacf_lookup.
`default_nettype none

package sacf_pkg;

  localparam int SETS        = 64;
  localparam int WAYS        = 4;
  localparam int BLOCK_BYTES = 64;
  localparam int ADDR_W      = 32;
  localparam int WAY_OUT_W   = 4;
  localparam int CNT_W       = 32;

  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

  localparam int OBITS    = floor_log2(BLOCK_BYTES);
  localparam int SBITS    = floor_log2(SETS);
  localparam int NUM_SETS = 1 << SBITS;
  localparam int SET_W    = (SBITS > 0) ? SBITS : 1;
  localparam int TAG_W    = ADDR_W - OBITS - SBITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef logic [SET_W-1:0]            set_t;
  typedef logic [TAG_W-1:0]            tag_t;
  typedef logic [WAY_W-1:0]            way_t;
  typedef logic [WAYS-1:0]             vld_t;
  typedef logic [WAYS-1:0][TAG_W-1:0]  tag_row_t;
  typedef logic [CNT_W-1:0]            cnt_t;

  typedef struct packed {
    logic hit;
    way_t way;
    way_t fp_nxt;
  } lk_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/set_assoc_cache_fifo_sim_top.sv
// Set-associative cache tag model, FIFO replacement, write-through counting.
// The block takes one access per cycle while the output is not stalled. An
// access is accepted and its set's tag row and FIFO pointer are read from
// synchronous RAM; the lookup stage then compares all ways and writes the
// result to the output register once that register is free. The single read
// port of the tag RAM sets the rate; back-to-back accesses to the same set are
// served by forwarding the row being written. Valid bits sit in flip-flops
// cleared by reset, so no clearing pass is needed after reset.
// Depends on sacf_pkg, sacf_ram, sacf_lookup and the assertion macro header.
`default_nettype none

`include "set_assoc_cache_fifo_sim_top_macros.svh"

module set_assoc_cache_fifo_sim_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_func,
  input  wire logic [sacf_pkg::ADDR_W-1:0] in_address,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_hit,
  output logic                             out_mem_read,
  output logic                             out_mem_write,
  output logic [sacf_pkg::WAY_OUT_W-1:0]   out_way_used,
  output logic [sacf_pkg::CNT_W-1:0]       out_read_count,
  output logic [sacf_pkg::CNT_W-1:0]       out_write_count,
  output logic [sacf_pkg::CNT_W-1:0]       out_hit_count,
  output logic [sacf_pkg::CNT_W-1:0]       out_miss_count
);

  import sacf_pkg::*;

  logic      in_acc;
  set_t      in_set;
  tag_t      in_tag;

  logic      s1_v_r;
  set_t      s1_set_r;
  tag_t      s1_tag_r;
  logic      s1_func_r;
  logic      fwd_r;
  tag_row_t  fwd_row_r;
  way_t      fwd_fp_r;

  logic      s1_adv;
  logic      s1_wr;
  logic [WAYS*TAG_W-1:0] ram_row;
  way_t      ram_fp;
  tag_row_t  cur_row;
  way_t      cur_fp;
  vld_t      cur_vld;
  tag_row_t  new_row;
  lk_res_t   lk;

  vld_t      vld_r [NUM_SETS];

  logic      out_v_r;
  logic      out_hit_r;
  logic      out_wr_r;
  way_t      out_way_r;
  cnt_t      miss_cnt_r;
  cnt_t      hit_cnt_r;
  cnt_t      wr_cnt_r;

  assign in_set = set_t'((in_address >> OBITS) & ADDR_W'(NUM_SETS - 1));
  assign in_tag = tag_t'(in_address >> (OBITS + SBITS));

  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign s1_wr    = s1_adv && !lk.hit;

  sacf_ram #(.WIDTH(WAYS * TAG_W), .DEPTH(NUM_SETS)) u_tag_ram (
    .clk   (clk),
    .we    (s1_wr),
    .waddr (s1_set_r),
    .wdata (new_row),
    .re    (in_acc),
    .raddr (in_set),
    .rdata (ram_row)
  );

  sacf_ram #(.WIDTH(WAY_W), .DEPTH(NUM_SETS)) u_fp_ram (
    .clk   (clk),
    .we    (s1_wr),
    .waddr (s1_set_r),
    .wdata (lk.fp_nxt),
    .re    (in_acc),
    .raddr (in_set),
    .rdata (ram_fp)
  );

  assign cur_row = fwd_r ? fwd_row_r : tag_row_t'(ram_row);
  assign cur_fp  = fwd_r ? fwd_fp_r : ram_fp;
  assign cur_vld = vld_r[s1_set_r];

  sacf_lookup u_lookup (
    .row (cur_row),
    .vld (cur_vld),
    .tag (s1_tag_r),
    .fp  (cur_fp),
    .res (lk)
  );

  always_comb begin
    new_row          = cur_row;
    new_row[lk.way]  = s1_tag_r;
  end

  // Lookup stage; forward the row being written when the next beat hits the same set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
      fwd_r  <= s1_wr && (s1_set_r == in_set);
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_set_r  <= in_set;
      s1_tag_r  <= in_tag;
      s1_func_r <= in_func;
      fwd_row_r <= new_row;
      fwd_fp_r  <= lk.fp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        vld_r[s] <= '0;
      end
    end else if (s1_wr) begin
      vld_r[s1_set_r][lk.way] <= 1'b1;
    end
  end

  // Counters only move when a new result is loaded, so they double as output fields.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r    <= 1'b0;
      miss_cnt_r <= '0;
      hit_cnt_r  <= '0;
      wr_cnt_r   <= '0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
      if (lk.hit) begin
        hit_cnt_r <= hit_cnt_r + 1'b1;
      end else begin
        miss_cnt_r <= miss_cnt_r + 1'b1;
      end
      if (s1_func_r == FUNC_WRITE) begin
        wr_cnt_r <= wr_cnt_r + 1'b1;
      end
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_hit_r <= lk.hit;
      out_wr_r  <= (s1_func_r == FUNC_WRITE);
      out_way_r <= lk.way;
    end
  end

  assign out_valid       = out_v_r;
  assign out_hit         = out_hit_r;
  assign out_mem_read    = !out_hit_r;
  assign out_mem_write   = out_wr_r;
  assign out_way_used    = WAY_OUT_W'(out_way_r);
  assign out_read_count  = miss_cnt_r;
  assign out_write_count = wr_cnt_r;
  assign out_hit_count   = hit_cnt_r;
  assign out_miss_count  = miss_cnt_r;

  `SACF_ASSERT_NEXT(a_fill_sets_valid, s1_wr, vld_r[$past(s1_set_r)][$past(lk.way)], "filled way not marked valid")
  `SACF_ASSERT_NEXT(a_one_count_per_beat, s1_adv, (CNT_W'(hit_cnt_r + miss_cnt_r) == CNT_W'($past(hit_cnt_r) + $past(miss_cnt_r) + 1'b1)), "hit plus miss count not advanced by one")
  `SACF_ASSERT_NOW(a_fwd_needs_lookup, fwd_r, s1_v_r, "forwarded row held with no lookup in flight")
  `SACF_ASSERT_NOW(a_stall_blocks_input, s1_v_r && out_v_r && !out_ready, !in_ready, "input taken while lookup stage is stalled")

endmodule

`default_nettype wire

>>> hw/rtl/sacf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies; used for the tag rows and the FIFO pointers.
`default_nettype none

module sacf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data between reads; a read beside a write to the same entry returns old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sacf_lookup.sv
// Tag compare and victim selection for one set of the cache.
// Depends on sacf_pkg for geometry and the lookup result type.
`default_nettype none

module sacf_lookup (
  input  wire sacf_pkg::tag_row_t row,
  input  wire sacf_pkg::vld_t     vld,
  input  wire sacf_pkg::tag_t     tag,
  input  wire sacf_pkg::way_t     fp,
  output sacf_pkg::lk_res_t       res
);

  import sacf_pkg::*;

  logic hit;
  way_t hit_way;
  logic empty;
  way_t empty_way;

  // Compare every way at once; lowest matching way wins.
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    empty     = 1'b0;
    empty_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && vld[i] && (row[i] == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!empty && !vld[i]) begin
        empty     = 1'b1;
        empty_way = WAY_W'(i);
      end
    end
  end

  // Fill empty ways in order; once full, replace the oldest and advance the pointer.
  always_comb begin
    res.hit = hit;
    if (hit) begin
      res.way    = hit_way;
      res.fp_nxt = fp;
    end else if (empty) begin
      res.way    = empty_way;
      res.fp_nxt = '0;
    end else begin
      res.way    = fp;
      res.fp_nxt = (fp == WAY_W'(WAYS - 1)) ? '0 : fp + 1'b1;
    end
  end

endmodule

`default_nettype wire
